/* design/lfsr_rwg_pkg.sv */
// lfsr_rwg_pkg: types, constants and the 64-advance transfer map of the lfsr word generator
// used by lfsr_rwg_adv, lfsr_random_word_generator_core and lfsr_rwg_checker
// no dependencies
package lfsr_rwg_pkg;

    localparam int unsigned STATE_W = 64;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned N_STEPS = 64;

    localparam logic [STATE_W-1:0] C_LFSR_INIT = 64'hdeadbeefcafebabe;

    // feedback tap sets, one per phase of the 64 advances
    localparam int unsigned PH1_END = 16;
    localparam int unsigned PH2_END = 48;
    localparam int unsigned TAP_A1  = 1;
    localparam int unsigned TAP_A2  = 3;
    localparam int unsigned TAP_A3  = 7;
    localparam int unsigned TAP_B1  = 17;
    localparam int unsigned TAP_B2  = 29;
    localparam int unsigned TAP_B3  = 43;
    localparam int unsigned TAP_C1  = 53;
    localparam int unsigned TAP_C2  = 59;
    localparam int unsigned TAP_C3  = 61;

    typedef enum logic [0:0] {
        OP_DRAW = 1'b0,
        OP_SEED = 1'b1
    } t_op;

    // row i: which bits of the old state xor together into bit i of the new state
    typedef logic [STATE_W-1:0][STATE_W-1:0] t_map;

    function automatic t_map f_adv_map();
        t_map               m;
        logic [STATE_W-1:0] fb;
        for (int i = 0; i < STATE_W; i++) begin
            m[i] = {{(STATE_W-1){1'b0}}, 1'b1} << i;
        end
        for (int s = 0; s < N_STEPS; s++) begin
            if (s < PH1_END) begin
                fb = m[0] ^ m[TAP_A1] ^ m[TAP_A2] ^ m[TAP_A3];
            end else if (s < PH2_END) begin
                fb = m[0] ^ m[TAP_B1] ^ m[TAP_B2] ^ m[TAP_B3];
            end else begin
                fb = m[0] ^ m[TAP_C1] ^ m[TAP_C2] ^ m[TAP_C3];
            end
            for (int i = 0; i < STATE_W - 1; i++) begin
                m[i] = m[i+1];
            end
            m[STATE_W-1] = fb;
        end
        return m;
    endfunction

    localparam t_map C_ADV_MAP = f_adv_map();

endpackage

/* design/lfsr_random_word_generator_core.sv */
// lfsr random word generator, 64-bit shift register, 32-bit words out
// a draw waits in the input reg while the output stalls; its word then goes to the result reg
// throughput: 1 item per cycle unless a draw stalls; all 64 advances run in one xor layer
// a seed item updates the state and produces no result
// reset (i_rst_n low, synchronous): state = 0xdeadbeefcafebabe, both stages emptied
// depends on lfsr_rwg_pkg and lfsr_rwg_adv
module lfsr_random_word_generator_core
    import lfsr_rwg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [WORD_W-1:0] s_axis_tdata,   // [31:0] seed_value
    input  logic [0:0]        s_axis_tuser,   // [0] operation
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [WORD_W-1:0] m_axis_tdata    // [31:0] random_word
);

    logic               r_in_valid;
    t_op                r_in_op;
    logic [WORD_W-1:0]  r_in_seed;
    logic [STATE_W-1:0] r_state;
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_out_word;

    logic [STATE_W-1:0] adv_state;
    logic               proceed;
    logic               s_accept;

    lfsr_rwg_adv u_adv (
        .i_state (r_state),
        .o_state (adv_state)
    );

    // seed items need no result slot, draws need the output free or leaving
    assign proceed  = r_in_valid && ((r_in_op == OP_SEED) || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || proceed;
    assign s_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= C_LFSR_INIT;
        end else begin
            if (s_accept) begin
                r_in_valid <= 1'b1;
            end else if (proceed) begin
                r_in_valid <= 1'b0;
            end

            if (proceed) begin
                unique case (r_in_op)
                    OP_SEED: r_state <= {{(STATE_W-WORD_W){1'b0}}, r_in_seed} ^ C_LFSR_INIT;
                    OP_DRAW: r_state <= adv_state;
                    default: r_state <= r_state;
                endcase
            end

            if (proceed && (r_in_op == OP_DRAW)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_op   <= t_op'(s_axis_tuser[0]);
            r_in_seed <= s_axis_tdata;
        end
        if (proceed && (r_in_op == OP_DRAW)) begin
            r_out_word <= adv_state[WORD_W-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_word;

endmodule

/* design/lfsr_rwg_adv.sv */
// lfsr_rwg_adv: applies the 64-advance shift register transfer in one pass
// each new state bit is an xor of old bits selected by a constant row of lfsr_rwg_pkg
module lfsr_rwg_adv
    import lfsr_rwg_pkg::*;
(
    input  logic [STATE_W-1:0] i_state,
    output logic [STATE_W-1:0] o_state
);

    always_comb begin
        for (int i = 0; i < STATE_W; i++) begin
            o_state[i] = ^(i_state & C_ADV_MAP[i]);
        end
    end

endmodule

/* design/lfsr_rwg_checker.sv */
// lfsr_rwg_checker: port-level checks on lfsr_random_word_generator_core, bound below
// depends on lfsr_rwg_pkg
module lfsr_rwg_checker
    import lfsr_rwg_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic [0:0]        s_axis_tuser,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [WORD_W-1:0] m_axis_tdata
);

    logic draw_accept;
    assign draw_accept = s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_DRAW);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a fresh result comes from an accepted draw item
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(draw_accept, 2))
        else $error("result without a draw item");

    // with the output empty the input side is never blocked
    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind lfsr_random_word_generator_core lfsr_rwg_checker u_lfsr_rwg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/sv/lfsr_rwg_word_checker.sv */
`timescale 1ns / 100ps
// lfsr_rwg_word_checker: watches both streams of the lfsr word generator and predicts each word
// keeps its own copy of the 64-bit shift register and a queue of expected words
// depends on lfsr_rwg_pkg
module lfsr_rwg_word_checker
    import lfsr_rwg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [WORD_W-1:0] i_in_seed,
    input  logic [0:0]        i_in_op,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [WORD_W-1:0] i_out_word,
    output int                o_fail_count,
    output int                o_words_pending
);

    logic [STATE_W-1:0] lfsr_state = C_LFSR_INIT;
    logic [STATE_W-1:0] lfsr_next;
    logic [WORD_W-1:0]  words_expected[$];
    logic [WORD_W-1:0]  word_want;
    int                 fail_total = 0;

    // 64 advances; the tap set changes at step 16 and at step 48
    function automatic logic [STATE_W-1:0] lfsr_run_draw(input logic [STATE_W-1:0] st);
        logic [STATE_W-1:0] r;
        logic               fb;
        r = st;
        for (int step = 0; step < N_STEPS; step++) begin
            if (step < PH1_END) begin
                fb = r[0] ^ r[TAP_A1] ^ r[TAP_A2] ^ r[TAP_A3];
            end else if (step < PH2_END) begin
                fb = r[0] ^ r[TAP_B1] ^ r[TAP_B2] ^ r[TAP_B3];
            end else begin
                fb = r[0] ^ r[TAP_C1] ^ r[TAP_C2] ^ r[TAP_C3];
            end
            r = {fb, r[STATE_W-1:1]};
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lfsr_state <= C_LFSR_INIT;
            words_expected.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (words_expected.size() == 0) begin
                    $display("%0t: unexpected random_word, expected none, actual %h",
                             $time, i_out_word);
                    fail_total++;
                end else begin
                    word_want = words_expected.pop_front();
                    if (i_out_word !== word_want) begin
                        $display("%0t: random_word mismatch, expected %h, actual %h",
                                 $time, word_want, i_out_word);
                        fail_total++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (t_op'(i_in_op) == OP_SEED) begin
                    lfsr_state <= {{(STATE_W-WORD_W){1'b0}}, i_in_seed} ^ C_LFSR_INIT;
                end else begin
                    lfsr_next = lfsr_run_draw(lfsr_state);
                    words_expected.push_back(lfsr_next[WORD_W-1:0]);
                    lfsr_state <= lfsr_next;
                end
            end
        end
        o_fail_count    <= fail_total;
        o_words_pending <= words_expected.size();
    end

endmodule

/* tb/sv/lfsr_random_word_generator_core_tb.sv */
`timescale 1ns / 100ps
// lfsr_random_word_generator_core_tb: drives seed and draw items with random stalls on both sides
// depends on lfsr_rwg_pkg, lfsr_random_word_generator_core and lfsr_rwg_word_checker
module lfsr_random_word_generator_core_tb;
    import lfsr_rwg_pkg::*;

    logic              i_clk     = 1'b0;
    logic              rst_n     = 1'b0;
    logic              src_valid = 1'b0;
    logic              src_ready;
    logic [WORD_W-1:0] src_seed  = '0;
    logic [0:0]        src_op    = OP_DRAW;
    logic              snk_valid;
    logic              snk_ready = 1'b0;
    logic [WORD_W-1:0] snk_word;
    int                fail_count;
    int                words_pending;
    int                src_idle_pct = 16;
    int                snk_idle_pct = 64;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    lfsr_random_word_generator_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (src_valid),
        .s_axis_tready (src_ready),
        .s_axis_tdata  (src_seed),   // [31:0] seed_value
        .s_axis_tuser  (src_op),     // [0] operation
        .m_axis_tvalid (snk_valid),
        .m_axis_tready (snk_ready),
        .m_axis_tdata  (snk_word)    // [31:0] random_word
    );

    lfsr_rwg_word_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (src_valid),
        .i_in_ready      (src_ready),
        .i_in_seed       (src_seed),
        .i_in_op         (src_op),
        .i_out_valid     (snk_valid),
        .i_out_ready     (snk_ready),
        .i_out_word      (snk_word),
        .o_fail_count    (fail_count),
        .o_words_pending (words_pending)
    );

    always @(posedge i_clk) begin
        snk_ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // present one item, with random idle cycles ahead of it, and wait for it to be taken
    task automatic offer_item(input t_op op, input logic [WORD_W-1:0] seed);
        while ($urandom_range(99) < src_idle_pct) begin
            src_valid <= 1'b0;
            @(posedge i_clk);
        end
        src_valid <= 1'b1;
        src_op    <= op;
        src_seed  <= seed;
        @(posedge i_clk);
        while (!src_ready) @(posedge i_clk);
    endtask

    task automatic random_items(input int count);
        logic [WORD_W-1:0] seed;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(7))
                0:       seed = '0;
                1:       seed = '1;
                2:       seed = 32'hcafebabe;
                default: seed = $urandom;
            endcase
            // mostly draws, with a seed load now and then
            if ($urandom_range(9) < 2) begin
                offer_item(OP_SEED, seed);
            end else begin
                offer_item(OP_DRAW, seed);
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // draws straight from the reset state, seed field ignored on a draw
        offer_item(OP_DRAW, '0);
        offer_item(OP_DRAW, '1);
        offer_item(OP_DRAW, 32'h5a5a5a5a);
        // seed extremes
        offer_item(OP_SEED, '0);
        offer_item(OP_DRAW, '0);
        offer_item(OP_DRAW, 32'ha5a5a5a5);
        offer_item(OP_SEED, '1);
        offer_item(OP_DRAW, '1);
        offer_item(OP_DRAW, '0);
        // low half of the state cleared: register holds deadbeef00000000
        offer_item(OP_SEED, 32'hcafebabe);
        offer_item(OP_DRAW, '0);
        offer_item(OP_DRAW, '0);
        offer_item(OP_DRAW, '0);
        // back to back seeds, only the last one counts
        offer_item(OP_SEED, 32'h00000001);
        offer_item(OP_SEED, 32'h80000000);
        offer_item(OP_DRAW, 32'h12345678);
        offer_item(OP_SEED, 32'h35014541);
        offer_item(OP_DRAW, '1);
        offer_item(OP_DRAW, 32'h80000001);
        offer_item(OP_SEED, 32'hffff0000);
        offer_item(OP_DRAW, 32'h0000ffff);

        random_items(317);
        src_idle_pct = 64;
        snk_idle_pct = 16;
        random_items(317);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        random_items(317);

        src_valid <= 1'b0;
        @(posedge i_clk);
        while (words_pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("lfsr_random_word_generator_core_tb passed");
        end else begin
            $display("lfsr_random_word_generator_core_tb failed");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("lfsr_random_word_generator_core_tb failed");
        $finish;
    end

endmodule
